### rtl/osa_edit_distance_macros.svh
// Assertion macros for the optimal string alignment distance engine.
// Used by the top level; depends on nothing else.
`ifndef OSA_EDIT_DISTANCE_MACROS_SVH
`define OSA_EDIT_DISTANCE_MACROS_SVH

// Checks a property on the rising clock edge, ignored while reset is high.
`define OSA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checks a property on the rising clock edge, also during reset.
`define OSA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/osa_pkg.sv
// Shared types and constants of the optimal string alignment distance engine.
// Used by the controller, the datapath and the top level; depends on nothing.
package osa_pkg;

   // Field widths of the request and response channels.
   localparam int KIND_W = 2;
   localparam int CHAR_W = 8;
   localparam int DIST_W = 6;

   // Default string capacity and the largest distance that fits the response.
   localparam int MAX_LEN_DEFAULT = 32;
   localparam logic [DIST_W-1:0] DIST_SAT = '1;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SECOND = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic store_first;
      logic set_ovf;
      logic row_begin;
      logic row_step;
      logic fin_read;
      logic fin_out;
   } osa_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic second_empty;
      logic first_full;
      logic second_full;
      logic cell_last;
   } osa_status_type;

endpackage

### rtl/osa_ctrl.sv
// Controller state machine of the optimal string alignment distance engine.
// Depends on osa_pkg for the request kinds and the command and status structs.
module osa_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [osa_pkg::KIND_W-1:0]    req_kind,
   input  osa_pkg::osa_status_type       status,
   output osa_pkg::osa_cmd_type          cmd,
   output logic                          busy
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ROW  = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Decode a request transfer and sequence the row walk and the finish.
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_kind)
                  osa_pkg::KIND_FIRST: begin
                     // First-string bytes are ignored once the second string has begun.
                     if (status.second_empty) begin
                        if (status.first_full) begin
                           cmd.set_ovf = 1'b1;
                        end else begin
                           cmd.store_first = 1'b1;
                        end
                     end
                  end
                  osa_pkg::KIND_SECOND: begin
                     if (status.second_full) begin
                        cmd.set_ovf = 1'b1;
                     end else begin
                        cmd.row_begin = 1'b1;
                        state_in      = S_ROW;
                     end
                  end
                  osa_pkg::KIND_FINISH: begin
                     cmd.fin_read = 1'b1;
                     state_in     = S_FIN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ROW: begin
            cmd.row_step = 1'b1;
            if (status.cell_last) begin
               state_in = S_IDLE;
            end
         end
         S_FIN: begin
            cmd.fin_out = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

### rtl/osa_datapath.sv
// Datapath of the optimal string alignment distance engine: string and row
// memories, the cell update and the response registers. Depends on osa_pkg.
module osa_datapath #(
   parameter int MAX_LEN = osa_pkg::MAX_LEN_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [osa_pkg::CHAR_W-1:0]    req_char_code,
   input  osa_pkg::osa_cmd_type          cmd,
   output osa_pkg::osa_status_type       status,
   output logic                          rsp_valid,
   output logic [osa_pkg::DIST_W-1:0]    rsp_distance,
   output logic                          rsp_overflow
);

   // Lengths, row indexes and row values all range over 0 to MAX_LEN.
   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int AW = $clog2(MAX_LEN);
   localparam int CW = osa_pkg::CHAR_W;

   // Memories: the first string and the last two rows.
   logic [CW-1:0] first_mem  [MAX_LEN];
   logic [LW-1:0] last_mem   [MAX_LEN+1];
   logic [LW-1:0] before_mem [MAX_LEN+1];

   // Pair state.
   logic [LW-1:0] first_len_ff;
   logic [LW-1:0] second_len_ff;
   logic [CW-1:0] prev_char_ff;
   logic          ovf_ff;
   logic [CW-1:0] char_ff;

   // Row walk: cell index and the registered read data.
   logic [LW-1:0] cidx_ff;
   logic [LW-1:0] rd_idx_ff;
   logic          use_init_ff;
   logic [LW-1:0] last_rd_ff;
   logic [LW-1:0] before_rd_ff;
   logic [CW-1:0] first_rd_ff;

   // Values of the previous cells kept along the walk.
   logic [LW-1:0] prev_last_ff;
   logic [LW-1:0] prev_fresh_ff;
   logic [CW-1:0] prev_a_ff;
   logic [LW-1:0] before_d1_ff;
   logic [LW-1:0] before_d2_ff;

   // Response registers.
   logic                       rsp_valid_ff;
   logic [osa_pkg::DIST_W-1:0] rsp_distance_ff;
   logic                       rsp_overflow_ff;

   logic          rd_en;
   logic [LW-1:0] rd_addr;
   logic          fc_rd_en;
   logic [LW-1:0] last_val;
   logic [LW-1:0] j_val;
   logic [LW:0]   del_c;
   logic [LW:0]   ins_c;
   logic [LW:0]   sub_c;
   logic [LW:0]   trn_c;
   logic [LW:0]   best_a;
   logic [LW:0]   best_b;
   logic [LW:0]   best_c;
   logic          trn_ok;
   logic [LW-1:0] cell_val;
   logic [8:0]    dist_wide;

   // Status for the controller.
   assign status.second_empty = (second_len_ff == '0);
   assign status.first_full   = (first_len_ff == LW'(MAX_LEN));
   assign status.second_full  = (second_len_ff == LW'(MAX_LEN));
   assign status.cell_last    = (cidx_ff == first_len_ff);

   // Read address: cell 0 on row start, the final entry on finish, else the next cell.
   always_comb begin
      rd_en    = cmd.row_begin | cmd.fin_read | (cmd.row_step & ~status.cell_last);
      fc_rd_en = cmd.row_step & ~status.cell_last;
      if (cmd.row_begin) begin
         rd_addr = '0;
      end else if (cmd.fin_read) begin
         rd_addr = first_len_ff;
      end else begin
         rd_addr = cidx_ff + 1'b1;
      end
   end

   // The last row reads as its initial value until a second-string byte is in.
   assign last_val = use_init_ff ? rd_idx_ff : last_rd_ff;
   assign j_val    = second_len_ff + 1'b1;

   // Cell update: deletion, insertion, substitution and adjacent transposition.
   always_comb begin
      del_c  = {1'b0, last_val} + 1'b1;
      ins_c  = {1'b0, prev_fresh_ff} + 1'b1;
      sub_c  = {1'b0, prev_last_ff} + {{LW{1'b0}}, (first_rd_ff != char_ff)};
      trn_c  = {1'b0, before_d2_ff} + 1'b1;
      trn_ok = (cidx_ff > LW'(1)) && !status.second_empty &&
               (first_rd_ff == prev_char_ff) && (prev_a_ff == char_ff);
      best_a = (del_c < ins_c) ? del_c : ins_c;
      best_b = (sub_c < best_a) ? sub_c : best_a;
      best_c = (trn_ok && (trn_c < best_b)) ? trn_c : best_b;
      if (cidx_ff == '0) begin
         cell_val = j_val;
      end else begin
         cell_val = best_c[LW-1:0];
      end
   end

   // Widen the final entry for the saturation compare.
   assign dist_wide = 9'(last_val);

   // Memory writes and registered reads.
   always_ff @(posedge clock) begin
      if (cmd.store_first) begin
         first_mem[first_len_ff[AW-1:0]] <= req_char_code;
      end
      if (cmd.row_step) begin
         last_mem[cidx_ff]   <= cell_val;
         before_mem[cidx_ff] <= last_val;
      end
      if (rd_en) begin
         last_rd_ff   <= last_mem[rd_addr];
         before_rd_ff <= before_mem[rd_addr];
         rd_idx_ff    <= rd_addr;
         use_init_ff  <= status.second_empty;
      end
      if (fc_rd_en) begin
         first_rd_ff <= first_mem[cidx_ff[AW-1:0]];
      end
   end

   // Walk registers: cell index and the values of the cells behind it.
   always_ff @(posedge clock) begin
      if (cmd.row_begin) begin
         cidx_ff <= '0;
         char_ff <= req_char_code;
      end else if (cmd.row_step) begin
         cidx_ff       <= cidx_ff + 1'b1;
         prev_last_ff  <= last_val;
         prev_fresh_ff <= cell_val;
         prev_a_ff     <= first_rd_ff;
         before_d1_ff  <= before_rd_ff;
         before_d2_ff  <= before_d1_ff;
      end
   end

   // Pair state: lengths, previous second-string byte and the overflow flag.
   always_ff @(posedge clock) begin
      if (reset || cmd.fin_out) begin
         first_len_ff  <= '0;
         second_len_ff <= '0;
         prev_char_ff  <= '0;
         ovf_ff        <= 1'b0;
      end else begin
         if (cmd.store_first) begin
            first_len_ff <= first_len_ff + 1'b1;
         end
         if (cmd.set_ovf) begin
            ovf_ff <= 1'b1;
         end
         if (cmd.row_step && status.cell_last) begin
            second_len_ff <= j_val;
            prev_char_ff  <= char_ff;
         end
      end
   end

   // Response strobe and payload, shown for one cycle after a finish.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.fin_out;
      end
      if (cmd.fin_out) begin
         if (dist_wide > 9'(osa_pkg::DIST_SAT)) begin
            rsp_distance_ff <= osa_pkg::DIST_SAT;
         end else begin
            rsp_distance_ff <= dist_wide[osa_pkg::DIST_W-1:0];
         end
         rsp_overflow_ff <= ovf_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

### rtl/osa_edit_distance.sv
// Optimal string alignment distance engine, top level: controller and datapath.
// Depends on osa_pkg, osa_ctrl, osa_datapath and osa_edit_distance_macros.svh.
// A first-string byte is taken without raising busy; a second-string byte starts
// a row walk of one cell per cycle through the single read port of the row
// memories; a finish reads the final entry and strobes its result on rsp_valid
// for one cycle once busy has fallen. Results cannot be stalled.
// Reset is synchronous and active high: it empties both strings and clears the flag.
module osa_edit_distance #(
   parameter int MAX_LEN = osa_pkg::MAX_LEN_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [osa_pkg::KIND_W-1:0]    req_kind,
   input  logic [osa_pkg::CHAR_W-1:0]    req_char_code,
   output logic                          rsp_valid,
   output logic [osa_pkg::DIST_W-1:0]    rsp_distance,
   output logic                          rsp_overflow
);

`include "osa_edit_distance_macros.svh"

   osa_pkg::osa_cmd_type    cmd;
   osa_pkg::osa_status_type status;

   // Controller: decodes request transfers and sequences the row walk.
   osa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // Datapath: memories, cell update and response registers.
   osa_datapath #(
      .MAX_LEN (MAX_LEN)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_char_code (req_char_code),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_distance  (rsp_distance),
      .rsp_overflow  (rsp_overflow)
   );

   // A result follows a busy cycle and the block is free again when it shows.
   `OSA_ASSERT(a_rsp_after_busy, rsp_valid |-> ($past(busy) && !busy), "result without finish")
   // Every finish gives exactly one strobe.
   `OSA_ASSERT(a_rsp_single, rsp_valid |=> !rsp_valid, "result strobe repeated")
   // An accepted finish occupies the block for the next cycle.
   `OSA_ASSERT(a_fin_busy, (start && !busy && req_kind == osa_pkg::KIND_FINISH) |=> busy, "finish not started")
   // No row walk starts unless a second-string byte is taken.
   `OSA_ASSERT_ALWAYS(a_row_cmd, cmd.row_begin |-> (start && !busy && req_kind == osa_pkg::KIND_SECOND), "row walk without request")

endmodule
